### design/dawl_pkg.sv
package dawl_pkg;

    // Input item kinds carried on the slave tuser
    typedef enum logic [1:0] {
        ACT_LOAD_PIX = 2'd0,
        ACT_LOAD_WT  = 2'd1,
        ACT_COMPUTE  = 2'd2,
        ACT_NONE     = 2'd3
    } t_action;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_KERNEL_WIDTH  = 3'd0,
        CFG_KERNEL_HEIGHT = 3'd1,
        CFG_STRIDE_X      = 3'd2,
        CFG_STRIDE_Y      = 3'd3,
        CFG_PAD_X         = 3'd4,
        CFG_PAD_Y         = 3'd5,
        CFG_PLANE_HEIGHT  = 3'd6,
        CFG_PLANE_WIDTH   = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic [2:0] kernel_width;
        logic [2:0] kernel_height;
        logic [2:0] stride_x;
        logic [2:0] stride_y;
        logic [2:0] pad_x;
        logic [2:0] pad_y;
        logic [6:0] plane_height;
        logic [6:0] plane_width;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic start;
        logic wr_pix;
        logic wr_wt;
        logic issue;
        logic load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic no_taps;
        logic last_tap;
        logic pipe_busy;
        logic out_free;
    } t_sts;

    localparam int          COORD_W     = 11;
    localparam logic [23:0] SUM_MAG_MAX = 24'h800000;

    localparam logic [2:0] RST_KERNEL = 3'd3;
    localparam logic [2:0] RST_STRIDE = 3'd1;
    localparam logic [2:0] RST_PAD    = 3'd1;
    localparam logic [6:0] RST_PLANE  = 7'd64;

endpackage

### design/depthwise_adder_window_l1_unit.sv
// Channel   Direction  Transfer                      Payload
// s_*       in         s_tvalid & s_tready           tdata: row, col, sample; tuser: action
// m_*       out        m_tvalid & m_tready           tdata: out_row, out_col, sum; tuser: error
// i_cfg_*   in         i_cfg_we at the clock edge    index and value of one register
//
// A pixel or weight load, and an unused action, is accepted straight from the idle state.
// A compute walks kernel_height * kernel_width taps, one tap per cycle through
// the single read port of the pixel store plus a three-stage read/abs/accumulate drain;
// a query outside the plane or an empty kernel issues no taps.
// Reset is synchronous, active low; the stores are not cleared and hold garbage until loaded.
// The output register holds a result until taken while the next items are accepted;
// a compute stalls before its output load only if the previous result is still unread.
module depthwise_adder_window_l1_unit #(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int MAX_KERNEL = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [5:0] row, [11:6] col, [27:12] sample, [31:28] zero
    input  logic [1:0]  s_tuser,    // [1:0] action

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [5:0] out_row, [11:6] out_col, [35:12] sum, [39:36] zero
    output logic [0:0]  m_tuser,    // [0] error

    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [6:0]  i_cfg_wdata
);

    dawl_pkg::t_cfg    r_cfg;
    dawl_pkg::t_cmd    cmd;
    dawl_pkg::t_sts    sts;
    dawl_pkg::t_action action;

    logic [5:0]         out_row;
    logic [5:0]         out_col;
    logic signed [23:0] out_sum;
    logic               out_err;

    assign action = dawl_pkg::t_action'(s_tuser);

    // Configuration registers: take the write, mask to the register width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kernel_width  <= dawl_pkg::RST_KERNEL;
            r_cfg.kernel_height <= dawl_pkg::RST_KERNEL;
            r_cfg.stride_x      <= dawl_pkg::RST_STRIDE;
            r_cfg.stride_y      <= dawl_pkg::RST_STRIDE;
            r_cfg.pad_x         <= dawl_pkg::RST_PAD;
            r_cfg.pad_y         <= dawl_pkg::RST_PAD;
            r_cfg.plane_height  <= dawl_pkg::RST_PLANE;
            r_cfg.plane_width   <= dawl_pkg::RST_PLANE;
        end else if (i_cfg_we) begin
            case (dawl_pkg::t_cfg_idx'(i_cfg_addr))
                dawl_pkg::CFG_KERNEL_WIDTH:  r_cfg.kernel_width  <= i_cfg_wdata[2:0];
                dawl_pkg::CFG_KERNEL_HEIGHT: r_cfg.kernel_height <= i_cfg_wdata[2:0];
                dawl_pkg::CFG_STRIDE_X:      r_cfg.stride_x      <= i_cfg_wdata[2:0];
                dawl_pkg::CFG_STRIDE_Y:      r_cfg.stride_y      <= i_cfg_wdata[2:0];
                dawl_pkg::CFG_PAD_X:         r_cfg.pad_x         <= i_cfg_wdata[2:0];
                dawl_pkg::CFG_PAD_Y:         r_cfg.pad_y         <= i_cfg_wdata[2:0];
                dawl_pkg::CFG_PLANE_HEIGHT:  r_cfg.plane_height  <= i_cfg_wdata;
                dawl_pkg::CFG_PLANE_WIDTH:   r_cfg.plane_width   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Sequence loads and tap walks
    dawl_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_tvalid),
        .i_action  (action),
        .o_s_ready (s_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    // Stores, window arithmetic, accumulator and output register
    dawl_datapath #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_row     (s_tdata[5:0]),
        .i_col     (s_tdata[11:6]),
        .i_sample  ($signed(s_tdata[27:12])),
        .i_m_ready (m_tready),
        .o_m_valid (m_tvalid),
        .o_out_row (out_row),
        .o_out_col (out_col),
        .o_sum     (out_sum),
        .o_error   (out_err)
    );

    assign m_tdata = {4'b0000, out_sum, out_col, out_row};
    assign m_tuser = out_err;

    // A new result appears only from a finished walk
    a_result_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(cmd.load_out))
        else $error("result raised without an output load");

    // Drop nothing: the result is loaded only after the last tap is accumulated
    a_load_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> !sts.pipe_busy)
        else $error("output loaded with taps in flight");

    // An out-of-plane query reports a zero sum
    a_error_sum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[35:12] == 24'd0))
        else $error("error result with nonzero sum");

    // The sum of negated magnitudes never turns positive
    a_sum_not_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[35] || (m_tdata[35:12] == 24'd0)))
        else $error("positive sum");

endmodule

### design/dawl_ctrl.sv
module dawl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_valid,
    input  dawl_pkg::t_action i_action,
    output logic             o_s_ready,
    input  dawl_pkg::t_sts   i_sts,
    output dawl_pkg::t_cmd   o_cmd
);

    dawl_pkg::t_state r_state;
    dawl_pkg::t_state n_state;
    logic             fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dawl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_s_ready = 1'b0;
        o_cmd     = '0;
        fire      = 1'b0;
        case (r_state)
            dawl_pkg::ST_IDLE: begin
                o_s_ready = 1'b1;
                fire      = i_s_valid;
                o_cmd.wr_pix = fire && (i_action == dawl_pkg::ACT_LOAD_PIX);
                o_cmd.wr_wt  = fire && (i_action == dawl_pkg::ACT_LOAD_WT);
                o_cmd.start  = fire && (i_action == dawl_pkg::ACT_COMPUTE);
                if (o_cmd.start) begin
                    n_state = dawl_pkg::ST_RUN;
                end
            end
            dawl_pkg::ST_RUN: begin
                if (i_sts.no_taps) begin
                    n_state = dawl_pkg::ST_DRAIN;
                end else begin
                    o_cmd.issue = 1'b1;
                    if (i_sts.last_tap) begin
                        n_state = dawl_pkg::ST_DRAIN;
                    end
                end
            end
            dawl_pkg::ST_DRAIN: begin
                // wait for the last tap to land and the output register to be free, then hand over to it
                if (!i_sts.pipe_busy && i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = dawl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dawl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### design/dawl_datapath.sv
module dawl_datapath #(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int MAX_KERNEL = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dawl_pkg::t_cfg      i_cfg,
    input  dawl_pkg::t_cmd      i_cmd,
    output dawl_pkg::t_sts      o_sts,
    input  logic [5:0]          i_row,
    input  logic [5:0]          i_col,
    input  logic signed [15:0]  i_sample,
    input  logic                i_m_ready,
    output logic                o_m_valid,
    output logic [5:0]          o_out_row,
    output logic [5:0]          o_out_col,
    output logic signed [23:0]  o_sum,
    output logic                o_error
);

    localparam int RW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW        = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int KW        = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int PIX_DEPTH = 1 << (RW + CW);
    localparam int WT_DEPTH  = 1 << (2 * KW);
    localparam int CDW       = dawl_pkg::COORD_W;

    logic signed [15:0] r_pix_mem [PIX_DEPTH];
    logic signed [15:0] r_wt_mem  [WT_DEPTH];

    logic [2:0]            kh_n;
    logic [2:0]            kw_n;
    logic [CDW-1:0]        ph;
    logic [CDW-1:0]        pw;
    logic [8:0]            prod_h;
    logic [8:0]            prod_w;
    logic signed [CDW-1:0] h;
    logic signed [CDW-1:0] w;
    logic                  in_plane;
    logic [RW+CW-1:0]      pix_rd_addr;
    logic [2*KW-1:0]       wt_rd_addr;
    logic                  pix_wr_ok;
    logic                  wt_wr_ok;

    logic [5:0]            r_row;
    logic [5:0]            r_col;
    logic                  r_err;
    logic signed [CDW-1:0] r_base_h;
    logic signed [CDW-1:0] r_base_w;
    logic [KW-1:0]         r_kh;
    logic [KW-1:0]         r_kw;

    logic                  r_v1;
    logic                  r_in1;
    logic signed [15:0]    r_pix_q;
    logic signed [15:0]    r_wt_q;
    logic                  r_v2;
    logic [16:0]           r_mag;
    logic [23:0]           r_acc;

    logic signed [16:0]    diff;
    logic [16:0]           mag;
    logic [24:0]           acc_sum;
    logic [23:0]           n_acc;

    logic                  r_out_valid;
    logic [5:0]            r_out_row;
    logic [5:0]            r_out_col;
    logic [23:0]           r_out_sum;
    logic                  r_out_err;

    always_comb begin
        kh_n = (int'(i_cfg.kernel_height) > MAX_KERNEL) ? 3'(MAX_KERNEL) : i_cfg.kernel_height;
        kw_n = (int'(i_cfg.kernel_width) > MAX_KERNEL) ? 3'(MAX_KERNEL) : i_cfg.kernel_width;
        ph   = (int'(i_cfg.plane_height) > MAX_ROWS) ? CDW'(MAX_ROWS)
                                                     : CDW'(i_cfg.plane_height);
        pw   = (int'(i_cfg.plane_width) > MAX_COLS) ? CDW'(MAX_COLS)
                                                    : CDW'(i_cfg.plane_width);
        prod_h = i_row * i_cfg.stride_y;
        prod_w = i_col * i_cfg.stride_x;
    end

    // tap position and padding test
    always_comb begin
        h = r_base_h + $signed(CDW'(r_kh));
        w = r_base_w + $signed(CDW'(r_kw));
        in_plane = !h[CDW-1] && !w[CDW-1] && ($unsigned(h) < ph) && ($unsigned(w) < pw);
        pix_rd_addr = {RW'($unsigned(h)), CW'($unsigned(w))};
        wt_rd_addr  = {r_kh, r_kw};
        pix_wr_ok   = (int'(i_row) < MAX_ROWS) && (int'(i_col) < MAX_COLS);
        wt_wr_ok    = (int'(i_row) < MAX_KERNEL) && (int'(i_col) < MAX_KERNEL);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_pix && pix_wr_ok) begin
            r_pix_mem[{RW'(i_row), CW'(i_col)}] <= i_sample;
        end
        r_pix_q <= r_pix_mem[pix_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_wt && wt_wr_ok) begin
            r_wt_mem[{KW'(i_row), KW'(i_col)}] <= i_sample;
        end
        r_wt_q <= r_wt_mem[wt_rd_addr];
    end

    // query capture and tap counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_row    <= i_row;
            r_col    <= i_col;
            r_err    <= (CDW'(i_row) >= ph) || (CDW'(i_col) >= pw);
            r_base_h <= $signed({2'b00, prod_h}) - $signed(CDW'(i_cfg.pad_y));
            r_base_w <= $signed({2'b00, prod_w}) - $signed(CDW'(i_cfg.pad_x));
            r_kh     <= '0;
            r_kw     <= '0;
        end else if (i_cmd.issue) begin
            if (int'(r_kw) + 1 == int'(kw_n)) begin
                r_kw <= '0;
                r_kh <= r_kh + 1'b1;
            end else begin
                r_kw <= r_kw + 1'b1;
            end
        end
        r_in1 <= in_plane;
    end

    always_comb begin
        if (r_in1) begin
            diff = {r_pix_q[15], r_pix_q} - {r_wt_q[15], r_wt_q};
        end else begin
            diff = -{r_wt_q[15], r_wt_q};
        end
        mag     = diff[16] ? 17'(-diff) : 17'(diff);
        acc_sum = {1'b0, r_acc} + 25'(r_mag);
        n_acc   = (acc_sum > 25'(dawl_pkg::SUM_MAG_MAX)) ? dawl_pkg::SUM_MAG_MAX
                                                         : acc_sum[23:0];
    end

    always_ff @(posedge i_clk) begin
        r_mag <= mag;
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_row <= r_row;
            r_out_col <= r_col;
            r_out_sum <= 24'd0 - r_acc;
            r_out_err <= r_err;
        end
    end

    always_comb begin
        o_sts.no_taps   = r_err || (kh_n == 3'd0) || (kw_n == 3'd0);
        o_sts.last_tap  = (int'(r_kh) + 1 == int'(kh_n)) && (int'(r_kw) + 1 == int'(kw_n));
        o_sts.pipe_busy = r_v1 || r_v2;
        o_sts.out_free  = !r_out_valid || i_m_ready;
    end

    assign o_m_valid = r_out_valid;
    assign o_out_row = r_out_row;
    assign o_out_col = r_out_col;
    assign o_sum     = $signed(r_out_sum);
    assign o_error   = r_out_err;

endmodule
